// File: rtl/core/affine_vertex_transform_2d_defines.svh
// Assertion macros used by the checker file.
`ifndef AFFINE_VERTEX_TRANSFORM_2D_DEFINES_SVH
`define AFFINE_VERTEX_TRANSFORM_2D_DEFINES_SVH

// Check a property while out of reset.
`define AVT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define AVT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/avt_pkg.sv
// Shared constants, types and codes of the affine vertex transform.
package avt_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int COEF_WIDTH  = 24;

  localparam int OP_W   = COORD_WIDTH + 1;
  localparam int PROD_W = COEF_WIDTH + OP_W;
  localparam int ACC_W  = ((PROD_W > OP_W + FRAC_BITS) ? PROD_W : OP_W + FRAC_BITS) + 2;
  localparam int Q_W    = ACC_W - FRAC_BITS;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = (COEF_WIDTH > COORD_WIDTH) ? COEF_WIDTH : COORD_WIDTH;
  localparam int MODE_W      = 3;
  localparam int VARIANT_W   = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_A   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_B   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_TRANSLATE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROTATE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCALE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REFLECT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SHEAR     = 3'd4;

  localparam logic [VARIANT_W-1:0] VARIANT_FIRST  = 2'd0;
  localparam logic [VARIANT_W-1:0] VARIANT_SECOND = 2'd1;
  localparam logic [VARIANT_W-1:0] VARIANT_THIRD  = 2'd2;
  localparam logic [VARIANT_W-1:0] REFLECT_LAST   = 2'd3;
  localparam logic [VARIANT_W-1:0] SHEAR_LAST     = 2'd1;

  localparam logic signed [COEF_WIDTH-1:0] COEF_A_RESET = COEF_WIDTH'(65536);

  typedef struct packed {
    logic [MODE_W-1:0]             mode;
    logic signed [COORD_WIDTH-1:0] offset_x;
    logic signed [COORD_WIDTH-1:0] offset_y;
    logic signed [COEF_WIDTH-1:0]  coef_a;
    logic signed [COEF_WIDTH-1:0]  coef_b;
  } cfg_t;

  // One coordinate: c1*o1 +/- c2*o2 + k*2^F.
  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] c1;
    logic signed [OP_W-1:0]       o1;
    logic signed [COEF_WIDTH-1:0] c2;
    logic signed [OP_W-1:0]       o2;
    logic                         sub;
    logic signed [OP_W-1:0]       k;
  } term_t;

  typedef struct packed {
    logic                 last;
    logic [VARIANT_W-1:0] variant;
  } meta_t;

  typedef struct packed {
    term_t tx;
    term_t ty;
    meta_t meta;
  } op_t;

endpackage

// File: rtl/core/affine_vertex_transform_2d.sv
// Top level of the 2D affine vertex transform pipeline.
// Each accepted vertex gives one result (translate, rotate, scale, unused
// modes), two (shear) or four (reflect), one result beat per cycle while
// the output is not stalled; the vertex holding stage expands an item into
// its beats and takes no new vertex until its last beat issues. A beat
// passes the registered stages in order: hold, operand select, multiply,
// sum, and round and saturate. Stall on the output backs up stage by stage
// and loses nothing. Load configuration only while no beat is in flight.
module affine_vertex_transform_2d (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [avt_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [avt_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [avt_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [avt_pkg::COORD_WIDTH-1:0] point_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [avt_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [avt_pkg::COORD_WIDTH-1:0] out_y,
  output logic [avt_pkg::VARIANT_W-1:0]          variant,
  output logic                                   last
);
  import avt_pkg::*;

  cfg_t  cfg;
  op_t   op;
  logic  op_valid;
  logic  prod_valid, sum_valid, res_valid;
  meta_t prod_meta, sum_meta, res_meta;
  logic  prod_ready, sum_ready, res_ready;
  logic signed [ACC_W-1:0] acc_x, acc_y;

  assign res_ready  = !res_valid || !out_stall;
  assign sum_ready  = !sum_valid || res_ready;
  assign prod_ready = !prod_valid || sum_ready;

  avt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  avt_issue u_issue (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .down_ready (prod_ready),
    .op_valid   (op_valid),
    .op         (op)
  );

  avt_mac u_mac_x (
    .clk     (clk),
    .en_prod (prod_ready),
    .en_sum  (sum_ready),
    .term    (op.tx),
    .acc     (acc_x)
  );

  avt_mac u_mac_y (
    .clk     (clk),
    .en_prod (prod_ready),
    .en_sum  (sum_ready),
    .term    (op.ty),
    .acc     (acc_y)
  );

  avt_round u_round_x (
    .clk   (clk),
    .en    (res_ready),
    .acc   (acc_x),
    .coord (out_x)
  );

  avt_round u_round_y (
    .clk   (clk),
    .en    (res_ready),
    .acc   (acc_y),
    .coord (out_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= op_valid;
      end
      if (sum_ready) begin
        sum_valid <= prod_valid;
      end
      if (res_ready) begin
        res_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready) begin
      prod_meta <= op.meta;
    end
    if (sum_ready) begin
      sum_meta <= prod_meta;
    end
    if (res_ready) begin
      res_meta <= sum_meta;
    end
  end

  assign out_valid = res_valid;
  assign variant   = res_meta.variant;
  assign last      = res_meta.last;

endmodule

// File: rtl/core/avt_cfg.sv
// Configuration register file of the affine vertex transform.
module avt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [avt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [avt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output avt_pkg::cfg_t                    cfg
);
  import avt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_TRANSLATE;
      cfg.offset_x <= '0;
      cfg.offset_y <= '0;
      cfg.coef_a   <= COEF_A_RESET;
      cfg.coef_b   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:     cfg.mode     <= cfg_data[MODE_W-1:0];
        REG_OFFSET_X: cfg.offset_x <= cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Y: cfg.offset_y <= cfg_data[COORD_WIDTH-1:0];
        REG_COEF_A:   cfg.coef_a   <= cfg_data[COEF_WIDTH-1:0];
        REG_COEF_B:   cfg.coef_b   <= cfg_data[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/avt_issue.sv
// Vertex holding stage: expands one vertex into its result beats and selects operands.
module avt_issue (
  input  logic                             clk,
  input  logic                             rst,
  input  avt_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [avt_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [avt_pkg::COORD_WIDTH-1:0] point_y,
  input  logic                             down_ready,
  output logic                             op_valid,
  output avt_pkg::op_t                     op
);
  import avt_pkg::*;

  logic                          busy;
  logic signed [COORD_WIDTH-1:0] vx;
  logic signed [COORD_WIDTH-1:0] vy;
  logic [VARIANT_W-1:0]          var_cnt;
  logic                          is_last;
  logic                          op_ready;
  logic                          emit;
  logic                          take;
  op_t                           op_next;

  logic signed [OP_W-1:0] x17, y17, px17, py17, dx, dy;

  assign x17  = OP_W'(vx);
  assign y17  = OP_W'(vy);
  assign px17 = OP_W'(cfg.offset_x);
  assign py17 = OP_W'(cfg.offset_y);
  assign dx   = x17 - px17;
  assign dy   = y17 - py17;

  always_comb begin
    case (cfg.mode)
      MODE_REFLECT: is_last = (var_cnt == REFLECT_LAST);
      MODE_SHEAR:   is_last = (var_cnt == SHEAR_LAST);
      default:      is_last = 1'b1;
    endcase
  end

  assign op_ready = !op_valid || down_ready;
  assign emit     = busy && op_ready;
  assign in_stall = busy && !(emit && is_last);
  assign take     = in_valid && !in_stall;

  always_comb begin
    op_next              = '0;
    op_next.tx.k         = x17;
    op_next.ty.k         = y17;
    op_next.meta.variant = var_cnt;
    op_next.meta.last    = is_last;
    case (cfg.mode)
      MODE_TRANSLATE: begin
        op_next.tx.k = x17 + px17;
        op_next.ty.k = y17 + py17;
      end
      MODE_ROTATE: begin
        op_next.tx.c1  = cfg.coef_a;
        op_next.tx.o1  = dx;
        op_next.tx.c2  = cfg.coef_b;
        op_next.tx.o2  = dy;
        op_next.tx.sub = 1'b1;
        op_next.tx.k   = px17;
        op_next.ty.c1  = cfg.coef_b;
        op_next.ty.o1  = dx;
        op_next.ty.c2  = cfg.coef_a;
        op_next.ty.o2  = dy;
        op_next.ty.k   = py17;
      end
      MODE_SCALE: begin
        op_next.tx.c1 = cfg.coef_a;
        op_next.tx.o1 = dx;
        op_next.tx.k  = px17;
        op_next.ty.c1 = cfg.coef_b;
        op_next.ty.o1 = dy;
        op_next.ty.k  = py17;
      end
      MODE_REFLECT: begin
        case (var_cnt)
          VARIANT_FIRST: begin
            op_next.ty.k = -y17;
          end
          VARIANT_SECOND: begin
            op_next.tx.k = -x17;
          end
          VARIANT_THIRD: begin
            op_next.tx.k = -x17;
            op_next.ty.k = -y17;
          end
          default: begin
            op_next.tx.k = y17;
            op_next.ty.k = x17;
          end
        endcase
      end
      MODE_SHEAR: begin
        if (var_cnt == VARIANT_FIRST) begin
          op_next.tx.c1 = cfg.coef_a;
          op_next.tx.o1 = y17;
        end else begin
          op_next.ty.c1 = cfg.coef_b;
          op_next.ty.o1 = x17;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      var_cnt  <= VARIANT_FIRST;
      op_valid <= 1'b0;
    end else begin
      if (take) begin
        busy    <= 1'b1;
        var_cnt <= VARIANT_FIRST;
      end else if (emit) begin
        var_cnt <= is_last ? VARIANT_FIRST : var_cnt + VARIANT_W'(1);
        if (is_last) begin
          busy <= 1'b0;
        end
      end
      if (op_ready) begin
        op_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      vx <= point_x;
      vy <= point_y;
    end
    if (op_ready) begin
      op <= op_next;
    end
  end

endmodule

// File: rtl/core/avt_mac.sv
// Product and sum stages for one coordinate.
module avt_mac (
  input  logic                                clk,
  input  logic                                en_prod,
  input  logic                                en_sum,
  input  avt_pkg::term_t                      term,
  output logic signed [avt_pkg::ACC_W-1:0]    acc
);
  import avt_pkg::*;

  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  logic signed [OP_W-1:0]   k;
  logic                     sub;
  logic signed [ACC_W-1:0]  acc_next;

  always_comb begin
    acc_next = ACC_W'(p1) + (ACC_W'(k) <<< FRAC_BITS);
    if (sub) begin
      acc_next = acc_next - ACC_W'(p2);
    end else begin
      acc_next = acc_next + ACC_W'(p2);
    end
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      p1  <= term.c1 * term.o1;
      p2  <= term.c2 * term.o2;
      k   <= term.k;
      sub <= term.sub;
    end
    if (en_sum) begin
      acc <= acc_next;
    end
  end

endmodule

// File: rtl/core/avt_round.sv
// Round half away from zero and saturate one coordinate into the output register.
module avt_round (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [avt_pkg::ACC_W-1:0]      acc,
  output logic signed [avt_pkg::COORD_WIDTH-1:0] coord
);
  import avt_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [Q_W-1:0]   HI   =
    {{(Q_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [Q_W-1:0]   LO   = ~HI;

  logic signed [ACC_W-1:0] biased;
  logic signed [Q_W-1:0]   q;
  logic signed [COORD_WIDTH-1:0] coord_next;

  always_comb begin
    biased = acc + (acc[ACC_W-1] ? HALF - ACC_W'(1) : HALF);
    q      = biased[ACC_W-1:FRAC_BITS];
    if (q > HI) begin
      coord_next = HI[COORD_WIDTH-1:0];
    end else if (q < LO) begin
      coord_next = LO[COORD_WIDTH-1:0];
    end else begin
      coord_next = q[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord <= coord_next;
    end
  end

endmodule

// File: rtl/core/avt_checker.sv
// Port-level checks of the affine vertex transform and their binding.
`include "affine_vertex_transform_2d_defines.svh"

module avt_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [avt_pkg::COORD_WIDTH-1:0] out_x,
  input logic signed [avt_pkg::COORD_WIDTH-1:0] out_y,
  input logic [avt_pkg::VARIANT_W-1:0]          variant,
  input logic                                   last
);
  import avt_pkg::*;

  logic                                   stalled;
  logic [2*COORD_WIDTH+VARIANT_W:0]       out_beat;

  assign stalled  = out_valid && out_stall;
  assign out_beat = {out_x, out_y, variant, last};

  `AVT_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output beat right after reset")

  `AVT_ASSERT(a_stall_hold, stalled |=> out_valid && $stable(out_beat), "stalled beat changed")

  `AVT_ASSERT(a_reflect_end, out_valid && variant == REFLECT_LAST |-> last, "reflect end not last")

  `AVT_ASSERT(a_reflect_mid, out_valid && variant == VARIANT_THIRD |-> !last, "third result last")

endmodule

bind affine_vertex_transform_2d avt_checker u_avt_checker (.*);
